### rtl/owdf_pkg.sv
// Shared types, constants and the letter lookup of the order word to decimal fraction block.
// Has no dependencies; every other file of the block but the queue imports it.
package owdf_pkg;

    localparam int LETTER_W          = 8;
    localparam int ADDR_W            = 11;
    localparam int CHAR_W            = 8;
    localparam int CODE_W            = 5;
    localparam int LETTER_COUNT      = 32;
    localparam int WORD_BITS_DEF     = 17;
    localparam int ADDRESS_BITS_DEF  = 11;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_ONE   = 8'h31;

    // Teleprinter alphabet; the position of a letter is its 5-bit code.
    localparam logic [CHAR_W-1:0] LETTER_TABLE [LETTER_COUNT] = '{
        8'h50, 8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55,
        8'h49, 8'h4F, 8'h4A, 8'h23, 8'h53, 8'h5A, 8'h4B, 8'h2A,
        8'h3F, 8'h46, 8'h40, 8'h44, 8'h21, 8'h48, 8'h4E, 8'h4D,
        8'h26, 8'h4C, 8'h58, 8'h47, 8'h41, 8'h42, 8'h43, 8'h56
    };

    typedef enum logic [1:0] {
        K_BAD       = 2'd0,
        K_ZERO      = 2'd1,
        K_MINUS_ONE = 2'd2,
        K_NORMAL    = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  neg;
    } t_desc;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_LEAD  = 2'd1,
        ST_POINT = 2'd2,
        ST_DIGIT = 2'd3
    } t_state;

    typedef struct packed {
        logic              found;
        logic [CODE_W-1:0] code;
    } t_lookup;

    // Each table entry is compared on its own; at most one can match.
    function automatic t_lookup letter_lookup(input logic [LETTER_W-1:0] letter);
        t_lookup res;
        res.found = 1'b0;
        res.code  = '0;
        for (int i = 0; i < LETTER_COUNT; i++) begin
            if (LETTER_TABLE[i] == letter) begin
                res.found = 1'b1;
                res.code  = CODE_W'(i);
            end
        end
        return res;
    endfunction

endpackage

### rtl/owdf_front.sv
// Front end: looks up the letter, packs the order word and classifies it.
// Depends on owdf_pkg; feeds the descriptor queue.
module owdf_front #(
    parameter int WORD_BITS    = owdf_pkg::WORD_BITS_DEF,
    parameter int ADDRESS_BITS = owdf_pkg::ADDRESS_BITS_DEF
) (
    input  logic [owdf_pkg::LETTER_W-1:0] i_order_letter,
    input  logic [owdf_pkg::ADDR_W-1:0]   i_address,
    input  logic                          i_long_word,
    output owdf_pkg::t_desc               o_desc,
    output logic [WORD_BITS-2:0]          o_mag
);
    import owdf_pkg::*;

    localparam int FRAC  = WORD_BITS - 1;
    localparam int RAW_W = CODE_W + ADDRESS_BITS + 1;
    localparam int CAT_W = (RAW_W > WORD_BITS) ? RAW_W : WORD_BITS;

    t_lookup                 lookup;
    logic [ADDRESS_BITS-1:0] addr;
    logic [CAT_W-1:0]        cat;
    logic [WORD_BITS-1:0]    word;
    logic [WORD_BITS-1:0]    neg_word;
    logic                    is_zero;
    logic                    is_min;

    assign lookup   = letter_lookup(i_order_letter);
    assign addr     = ADDRESS_BITS'(i_address);
    assign cat      = (CAT_W'(lookup.code) << (ADDRESS_BITS + 1))
                    | (CAT_W'(addr) << 1) | CAT_W'(i_long_word);
    assign word     = cat[WORD_BITS-1:0];
    assign neg_word = ~word + WORD_BITS'(1);
    assign is_zero  = (word == '0);
    assign is_min   = word[WORD_BITS-1] && (word[FRAC-1:0] == '0);

    always_comb begin
        o_desc.neg = word[WORD_BITS-1];
        if (!lookup.found) begin
            o_desc.kind = K_BAD;
        end else if (is_zero) begin
            o_desc.kind = K_ZERO;
        end else if (is_min) begin
            o_desc.kind = K_MINUS_ONE;
        end else begin
            o_desc.kind = K_NORMAL;
        end
        o_mag = word[WORD_BITS-1] ? neg_word[FRAC-1:0] : word[FRAC-1:0];
    end

endmodule

### rtl/owdf_queue.sv
// Two-entry queue that decouples the classifier from the text sequencer.
// Depends on no other file.
module owdf_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic [1:0]       n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### rtl/owdf_back.sv
// Back end: sequencer that writes the decimal text one character per transfer.
// Depends on owdf_pkg; drives the output register of the block.
module owdf_back #(
    parameter int WORD_BITS = owdf_pkg::WORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  owdf_pkg::t_desc             i_desc,
    input  logic [WORD_BITS-2:0]        i_mag,
    output logic                        o_q_pop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [owdf_pkg::CHAR_W-1:0] o_text_char,
    output logic                        o_last_char,
    output logic                        o_bad_letter
);
    import owdf_pkg::*;

    localparam int FRAC = WORD_BITS - 1;

    t_state             r_state, n_state;
    t_desc              r_desc, n_desc;
    logic [FRAC-1:0]    r_mag, n_mag;
    logic               r_valid, n_valid;
    logic [CHAR_W-1:0]  r_char, n_char;
    logic               r_last, n_last;
    logic               r_bad, n_bad;

    logic               adv;
    logic               emit;
    logic [CHAR_W-1:0]  ch;
    logic               last;
    logic               bad;
    logic [FRAC+3:0]    prod;

    assign adv  = !r_valid || !i_stall;
    // Times ten as two shifted copies added.
    assign prod = ({4'b0, r_mag} << 3) + ({4'b0, r_mag} << 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_desc <= n_desc;
        r_mag  <= n_mag;
        r_char <= n_char;
        r_last <= n_last;
        r_bad  <= n_bad;
    end

    always_comb begin
        n_state = r_state;
        n_desc  = r_desc;
        n_mag   = r_mag;
        o_q_pop = 1'b0;
        emit    = 1'b0;
        ch      = CHAR_ZERO;
        last    = 1'b0;
        bad     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid && adv) begin
                    o_q_pop = 1'b1;
                    emit    = 1'b1;
                    n_desc  = i_desc;
                    n_mag   = i_mag;
                    case (i_desc.kind)
                        K_BAD: begin
                            ch   = CHAR_NUL;
                            last = 1'b1;
                            bad  = 1'b1;
                        end
                        K_MINUS_ONE: begin
                            ch      = CHAR_MINUS;
                            n_state = ST_LEAD;
                        end
                        K_NORMAL: begin
                            if (i_desc.neg) begin
                                ch      = CHAR_MINUS;
                                n_state = ST_LEAD;
                            end else begin
                                ch      = CHAR_ZERO;
                                n_state = ST_POINT;
                            end
                        end
                        default: begin
                            ch      = CHAR_ZERO;
                            n_state = ST_POINT;
                        end
                    endcase
                end
            end
            ST_LEAD: begin
                if (adv) begin
                    emit    = 1'b1;
                    ch      = (r_desc.kind == K_MINUS_ONE) ? CHAR_ONE : CHAR_ZERO;
                    n_state = ST_POINT;
                end
            end
            ST_POINT: begin
                if (adv) begin
                    emit    = 1'b1;
                    ch      = CHAR_POINT;
                    n_state = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (adv) begin
                    emit = 1'b1;
                    if (r_desc.kind == K_NORMAL) begin
                        ch    = CHAR_ZERO + CHAR_W'(prod[FRAC+3:FRAC]);
                        n_mag = prod[FRAC-1:0];
                        last  = (prod[FRAC-1:0] == '0);
                    end else begin
                        ch   = CHAR_ZERO;
                        last = 1'b1;
                    end
                    if (last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (emit) begin
            n_valid = 1'b1;
            n_char  = ch;
            n_last  = last;
            n_bad   = bad;
        end else begin
            n_valid = r_valid && i_stall;
            n_char  = r_char;
            n_last  = r_last;
            n_bad   = r_bad;
        end
    end

    assign o_valid      = r_valid;
    assign o_text_char  = r_char;
    assign o_last_char  = r_last;
    assign o_bad_letter = r_bad;

endmodule

### rtl/order_word_to_decimal_fraction.sv
// Order word to decimal fraction: order letter, address and flag in, decimal text out.
// The input is written into the queue, and its first character is then registered in the output register.
// Throughput: one character per cycle while i_stall is low; the text of an item has
// 1 to WORD_BITS+2 characters, emitted one after another by the sequencer.
// Reset is synchronous, active low, and empties the queue and the output register.
module order_word_to_decimal_fraction #(
    parameter int WORD_BITS    = owdf_pkg::WORD_BITS_DEF,
    parameter int ADDRESS_BITS = owdf_pkg::ADDRESS_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [owdf_pkg::LETTER_W-1:0] i_order_letter,
    input  logic [owdf_pkg::ADDR_W-1:0]   i_address,
    input  logic                          i_long_word,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [owdf_pkg::CHAR_W-1:0]   o_text_char,
    output logic                          o_last_char,
    output logic                          o_bad_letter
);
    import owdf_pkg::*;

    localparam int FRAC  = WORD_BITS - 1;
    localparam int ENT_W = $bits(t_desc) + FRAC;

    t_desc            front_desc;
    logic [FRAC-1:0]  front_mag;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    logic [ENT_W-1:0] q_data;
    t_desc            back_desc;
    logic [FRAC-1:0]  back_mag;

    assign o_stall = q_full;

    owdf_front #(
        .WORD_BITS    (WORD_BITS),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_front (
        .i_order_letter (i_order_letter),
        .i_address      (i_address),
        .i_long_word    (i_long_word),
        .o_desc         (front_desc),
        .o_mag          (front_mag)
    );

    owdf_queue #(
        .WIDTH (ENT_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid && !q_full),
        .i_data  ({front_desc, front_mag}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign back_desc = t_desc'(q_data[ENT_W-1:FRAC]);
    assign back_mag  = q_data[FRAC-1:0];

    owdf_back #(
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_desc       (back_desc),
        .i_mag        (back_mag),
        .o_q_pop      (q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_text_char  (o_text_char),
        .o_last_char  (o_last_char),
        .o_bad_letter (o_bad_letter)
    );

endmodule

### rtl/owdf_checker.sv
// Port-level checks for the order word to decimal fraction block, bound to the top level.
// Depends on owdf_pkg and on the top level's port names.
module owdf_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic [owdf_pkg::LETTER_W-1:0] i_order_letter,
    input logic [owdf_pkg::ADDR_W-1:0]   i_address,
    input logic                          i_long_word,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [owdf_pkg::CHAR_W-1:0]   o_text_char,
    input logic                          o_last_char,
    input logic                          o_bad_letter
);
    import owdf_pkg::*;

    // A bad letter gives exactly one result, with a null character.
    a_bad_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_letter |-> o_last_char && (o_text_char == CHAR_NUL))
        else $error("bad letter result is not a single null character");

    // The text never ends in a sign or a decimal point.
    a_last_is_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_char && !o_bad_letter |->
            (o_text_char != CHAR_MINUS) && (o_text_char != CHAR_POINT))
        else $error("text ended on a sign or a point");

    // After a transfer of a non-final character, the bad letter flag stays low.
    a_no_bad_mid_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_char |=> !o_bad_letter)
        else $error("bad letter flag inside a text");

    // Nothing is shown in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_text_char) && $stable(o_last_char))
        else $error("stalled result changed");

endmodule

bind order_word_to_decimal_fraction owdf_checker u_owdf_checker (.*);

### tb/order_word_to_decimal_fraction_tb.sv
// Self-checking testbench for order_word_to_decimal_fraction: drives order letters and
// addresses, predicts the decimal text of each order word and checks every character.
// Depends on owdf_pkg and the order_word_to_decimal_fraction RTL.
module order_word_to_decimal_fraction_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import owdf_pkg::*;

    localparam int FRAC_BITS   = WORD_BITS_DEF - 1;
    localparam int TEXT_LIMIT  = WORD_BITS_DEF + 2;
    localparam int RANDOM_CNT  = 450;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 20;

    typedef struct {
        logic [LETTER_W-1:0] letter;
        logic [ADDR_W-1:0]   addr;
        logic                long_word;
    } t_order;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              bad;
    } t_text_char;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_valid        = 1'b0;
    logic                o_stall;
    logic [LETTER_W-1:0] i_order_letter = '0;
    logic [ADDR_W-1:0]   i_address      = '0;
    logic                i_long_word    = 1'b0;
    logic                o_valid;
    logic                i_stall        = 1'b0;
    logic [CHAR_W-1:0]   o_text_char;
    logic                o_last_char;
    logic                o_bad_letter;

    t_order     order_q[$];
    t_text_char text_expect_q[$];
    int         error_cnt    = 0;
    int         accepted_cnt = 0;
    int         burst_left   = 0;
    int         gap_left     = 0;
    int         hold_left    = 0;
    bit         hold_done    = 1'b0;
    int         phase_left   = 0;
    int         stall_mode   = 0;

    order_word_to_decimal_fraction uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_order_letter (i_order_letter),
        .i_address      (i_address),
        .i_long_word    (i_long_word),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_text_char    (o_text_char),
        .o_last_char    (o_last_char),
        .o_bad_letter   (o_bad_letter)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Packs the order word, reads it as a two's-complement fraction and queues the
    // characters of its exact decimal text.
    function automatic void predict_decimal_text(input t_order ord);
        logic                     found;
        logic [CODE_W-1:0]        code;
        logic [WORD_BITS_DEF-1:0] word;
        logic [FRAC_BITS+3:0]     mag;
        logic [CHAR_W-1:0]        txt[$];
        t_text_char               res;
        found = 1'b0;
        code  = '0;
        for (int i = 0; i < LETTER_COUNT; i++) begin
            if (!found && LETTER_TABLE[i] == ord.letter) begin
                found = 1'b1;
                code  = CODE_W'(i);
            end
        end
        if (!found) begin
            res.ch   = CHAR_NUL;
            res.last = 1'b1;
            res.bad  = 1'b1;
            text_expect_q.push_back(res);
            return;
        end
        word = {code, ord.addr, ord.long_word};
        if (word == {1'b1, {FRAC_BITS{1'b0}}}) begin
            txt = '{CHAR_MINUS, CHAR_ONE, CHAR_POINT, CHAR_ZERO};
        end else if (word == '0) begin
            txt = '{CHAR_ZERO, CHAR_POINT, CHAR_ZERO};
        end else begin
            if (word[WORD_BITS_DEF-1]) begin
                txt.push_back(CHAR_MINUS);
                word = -word;
            end
            mag = {4'b0, word[FRAC_BITS-1:0]};
            txt.push_back(CHAR_ZERO);
            txt.push_back(CHAR_POINT);
            while (mag != '0 && txt.size() < TEXT_LIMIT) begin
                mag = mag * 10;
                txt.push_back(CHAR_ZERO + CHAR_W'(mag[FRAC_BITS+3:FRAC_BITS]));
                mag[FRAC_BITS+3:FRAC_BITS] = '0;
            end
        end
        foreach (txt[k]) begin
            res.ch   = txt[k];
            res.last = (k == txt.size() - 1);
            res.bad  = 1'b0;
            text_expect_q.push_back(res);
        end
    endfunction

    function automatic void add_order(input logic [LETTER_W-1:0] letter,
                                      input logic [ADDR_W-1:0] addr, input logic lw);
        t_order ord;
        ord.letter    = letter;
        ord.addr      = addr;
        ord.long_word = lw;
        order_q.push_back(ord);
    endfunction

    // Sender: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin : order_driver
        t_order nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                nxt.letter    = i_order_letter;
                nxt.addr      = i_address;
                nxt.long_word = i_long_word;
                predict_decimal_text(nxt);
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    i_valid <= 1'b0;
                end else if (order_q.size() > 0) begin
                    nxt = order_q.pop_front();
                    i_order_letter <= nxt.letter;
                    i_address      <= nxt.addr;
                    i_long_word    <= nxt.long_word;
                    i_valid        <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left = burst_left - 1;
                    end else begin
                        burst_left = $urandom_range(0, 20);
                        gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: phases of differing stall density, plus one long hold-off that lets
    // the block fill up while the sender keeps offering orders.
    always @(posedge i_clk) begin : text_stall_gen
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else if (!hold_done && accepted_cnt >= 60) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            i_stall <= 1'b1;
        end else if (phase_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            phase_left = $urandom_range(20, 120);
            i_stall <= 1'b0;
        end else begin
            phase_left = phase_left - 1;
            case (stall_mode)
                0: begin
                    i_stall <= 1'b0;
                end
                1: begin
                    i_stall <= ($urandom_range(0, 3) == 0);
                end
                2: begin
                    i_stall <= 1'($urandom_range(0, 1));
                end
                default: begin
                    i_stall <= ($urandom_range(0, 3) != 0);
                end
            endcase
        end
    end

    always @(posedge i_clk) begin : text_checker
        t_text_char want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (text_expect_q.size() == 0) begin
                $display("%0t: unexpected character: expected none, actual %h last %b bad %b",
                         $time, o_text_char, o_last_char, o_bad_letter);
                error_cnt++;
            end else begin
                want = text_expect_q.pop_front();
                if (o_text_char !== want.ch) begin
                    $display("%0t: text_char mismatch: expected %h, actual %h",
                             $time, want.ch, o_text_char);
                    error_cnt++;
                end
                if (o_last_char !== want.last) begin
                    $display("%0t: last_char mismatch: expected %b, actual %b",
                             $time, want.last, o_last_char);
                    error_cnt++;
                end
                if (o_bad_letter !== want.bad) begin
                    $display("%0t: bad_letter mismatch: expected %b, actual %b",
                             $time, want.bad, o_bad_letter);
                    error_cnt++;
                end
            end
        end
    end

    initial begin : stimulus
        int                  pick;
        logic [LETTER_W-1:0] letter;
        logic [ADDR_W-1:0]   addr;
        // Zero word, most negative word, and the extremes of the fraction.
        add_order("P", 11'd0, 1'b0);
        add_order("?", 11'd0, 1'b0);
        add_order("V", 11'h7FF, 1'b1);
        add_order("P", 11'd0, 1'b1);
        add_order("*", 11'h7FF, 1'b1);
        add_order("?", 11'd0, 1'b1);
        add_order("F", 11'd0, 1'b0);
        add_order("F", 11'h400, 1'b0);
        add_order("Q", 11'd1, 1'b0);
        add_order("O", 11'h7FF, 1'b0);
        add_order("X", 11'h555, 1'b1);
        add_order("G", 11'h2AA, 1'b0);
        add_order("#", 11'h123, 1'b1);
        add_order("&", 11'h0F0, 1'b0);
        add_order("@", 11'h70F, 1'b1);
        add_order("!", 11'h001, 1'b1);
        add_order("C", 11'h3FF, 1'b1);
        // Letters missing from the table.
        add_order(8'h00, 11'h7FF, 1'b1);
        add_order(8'hFF, 11'd0, 1'b0);
        add_order("p", 11'h2AA, 1'b1);
        add_order(8'h80, 11'h555, 1'b0);
        for (int n = 0; n < RANDOM_CNT; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                add_order("?", 11'd0, 1'b0);
            end else if (pick < 8) begin
                add_order("P", 11'd0, 1'b0);
            end else begin
                if (pick < 25)
                    letter = 8'($urandom_range(0, 255));
                else
                    letter = LETTER_TABLE[$urandom_range(0, LETTER_COUNT - 1)];
                case ($urandom_range(0, 9))
                    0: addr = '0;
                    1: addr = '1;
                    default: addr = ADDR_W'($urandom_range(0, 2047));
                endcase
                add_order(letter, addr, 1'($urandom_range(0, 1)));
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (order_q.size() != 0 || i_valid)
            @(posedge i_clk);
        while (text_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (error_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
